// File: hdl/filtered_pid_controller_core_macros.svh
`ifndef FILTERED_PID_CONTROLLER_CORE_MACROS_SVH
`define FILTERED_PID_CONTROLLER_CORE_MACROS_SVH

// Both macros sample on the rising clock edge and are quiet while reset is held.

// The consequent must hold in the same cycle as the antecedent.
`define FPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("filtered pid check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("filtered pid check failed");

`endif

// File: hdl/fpc_pkg.sv
package fpc_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int SMOOTH_W = WEIGHT_W + 1;
    localparam int LIMIT_W  = DATA_W - 1;

    // Multiplier operands carry one extra bit so that unsigned elapsed times
    // and error differences fit as signed values.
    localparam int OPND_W  = DATA_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int SHIFT_MIN = (FRAC_W < WEIGHT_W) ? FRAC_W : WEIGHT_W;
    localparam int ACC_W   = PROD_W - SHIFT_MIN + 1;

    // Serial divider: magnitude of the error difference scaled up by FRAC_W.
    localparam int NUM_W = OPND_W + FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_P = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

    localparam logic [SMOOTH_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_W{1'b0}}};

    // A step is skipped when 10 * elapsed < 2^FRAC_W, i.e. elapsed < ceil(2^FRAC_W / 10).
    localparam logic [DATA_W-1:0] SKIP_LIMIT = DATA_W'(((1 << FRAC_W) + 9) / 10);

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef struct packed {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] measured;
        logic        [DATA_W-1:0] elapsed;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] prop_term;
        logic signed [DATA_W-1:0] integ_term;
        logic signed [DATA_W-1:0] deriv_term;
        logic                     skipped;
    } pid_out_t;

    typedef struct packed {
        logic                     load;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] diff;
        logic        [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_MAX) begin
            return {1'b0, {(DATA_W - 1){1'b1}}};
        end else if (v < ACC_MIN) begin
            return {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

// File: hdl/filtered_pid_controller_core.sv
// A beat runs CHECK, then ISSUE, MUL and ACC per product, then SUM and DONE; a skipped step
// goes straight to DONE. The derivative blend waits on the serial divider (one quotient bit a cycle).
// A new beat is accepted while the previous result still waits on the output register.
// Reset (aresetn low, synchronous) zeroes the filter, integral and last-error state,
// restores the configuration registers to their defaults and drops the output beat.
module filtered_pid_controller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fpc_pkg::pid_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fpc_pkg::pid_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpc_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DW = fpc_pkg::DATA_W;
    localparam int FW = fpc_pkg::FRAC_W;
    localparam int WW = fpc_pkg::WEIGHT_W;
    localparam int OW = fpc_pkg::OPND_W;
    localparam int PW = fpc_pkg::PROD_W;
    localparam int AW = fpc_pkg::ACC_W;
    localparam int SW = fpc_pkg::SMOOTH_W;
    localparam int LW = fpc_pkg::LIMIT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [2:0] OP_INTEG   = 3'd0;
    localparam logic [2:0] OP_BLEND_P = 3'd1;
    localparam logic [2:0] OP_SCALE_P = 3'd2;
    localparam logic [2:0] OP_SCALE_I = 3'd3;
    localparam logic [2:0] OP_BLEND_D = 3'd4;
    localparam logic [2:0] OP_SCALE_D = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;

    logic signed [DW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [SW-1:0]        smooth_p_reg, smooth_d_reg;
    logic [LW-1:0]        limit_reg;

    logic signed [DW-1:0] ferr_reg, integ_reg, last_err_reg, fslope_reg;

    fpc_pkg::pid_in_t     in_reg;
    logic signed [DW-1:0] err_reg;
    logic signed [DW-1:0] p_reg, i_reg, d_reg, drive_reg;
    logic                 skip_reg;
    fpc_pkg::pid_out_t    out_reg;

    fpc_pkg::mul_req_t    mul_req;
    logic signed [PW-1:0] prod;
    fpc_pkg::div_req_t    div_req;
    fpc_pkg::div_rsp_t    div_rsp;

    logic [SW-1:0]        weight_p, weight_d;
    logic                 skip;
    logic                 load_out;
    logic                 is_blend;
    logic signed [AW-1:0] err_full;
    logic signed [DW-1:0] err_sat;
    logic signed [AW-1:0] sh_frac, sh_wt;
    logic signed [AW-1:0] acc_base, acc_sum;
    logic signed [DW-1:0] acc_sat;
    logic signed [AW-1:0] lim_pos, lim_neg, integ_clamped;
    logic signed [AW-1:0] sum3;

    fpc_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    fpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // A weight above one acts as one.
    assign weight_p = smooth_p_reg[SW-1] ? fpc_pkg::WEIGHT_ONE : smooth_p_reg;
    assign weight_d = smooth_d_reg[SW-1] ? fpc_pkg::WEIGHT_ONE : smooth_d_reg;

    assign skip     = (in_reg.elapsed < fpc_pkg::SKIP_LIMIT);
    assign err_full = AW'(in_reg.target) - AW'(in_reg.measured);
    assign err_sat  = fpc_pkg::sat_acc(err_full);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    // Operand selection for the shared multiplier. The blends use the form
    // old + w * (new - old), so one product per filter is enough.
    always_comb begin
        mul_req.load = (state_reg == ST_ISSUE) && ((op_reg != OP_BLEND_D) || div_rsp.done);
        mul_req.a    = '0;
        mul_req.b    = '0;
        case (op_reg)
            OP_INTEG: begin
                mul_req.a = {1'b0, in_reg.elapsed};
                mul_req.b = OW'(err_reg);
            end
            OP_BLEND_P: begin
                mul_req.a = OW'(weight_p);
                mul_req.b = OW'(err_reg) - OW'(ferr_reg);
            end
            OP_SCALE_P: begin
                mul_req.a = OW'(ferr_reg);
                mul_req.b = OW'(gain_p_reg);
            end
            OP_SCALE_I: begin
                mul_req.a = OW'(integ_reg);
                mul_req.b = OW'(gain_i_reg);
            end
            OP_BLEND_D: begin
                mul_req.a = OW'(weight_d);
                mul_req.b = OW'(div_rsp.quot) - OW'(fslope_reg);
            end
            OP_SCALE_D: begin
                mul_req.a = OW'(fslope_reg);
                mul_req.b = OW'(gain_d_reg);
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // The divider starts with the first product and runs alongside the others.
    always_comb begin
        div_req.start   = (state_reg == ST_ISSUE) && (op_reg == OP_INTEG);
        div_req.diff    = OW'(err_reg) - OW'(last_err_reg);
        div_req.divisor = in_reg.elapsed;
    end

    always_comb begin
        is_blend = (op_reg == OP_BLEND_P) || (op_reg == OP_BLEND_D);
        sh_frac  = AW'($signed(prod[PW-1:FW]));
        sh_wt    = AW'($signed(prod[PW-1:WW]));
        case (op_reg)
            OP_INTEG:   acc_base = AW'(integ_reg);
            OP_BLEND_P: acc_base = AW'(ferr_reg);
            OP_BLEND_D: acc_base = AW'(fslope_reg);
            default:    acc_base = '0;
        endcase
        acc_sum = (is_blend ? sh_wt : sh_frac) + acc_base;
        acc_sat = fpc_pkg::sat_acc(acc_sum);

        lim_pos = AW'(limit_reg);
        lim_neg = -lim_pos;
        if (acc_sum > lim_pos) begin
            integ_clamped = lim_pos;
        end else if (acc_sum < lim_neg) begin
            integ_clamped = lim_neg;
        end else begin
            integ_clamped = acc_sum;
        end

        sum3 = AW'(p_reg) + AW'(i_reg) + AW'(d_reg);
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                op_next    = OP_INTEG;
                state_next = skip ? ST_DONE : ST_ISSUE;
            end
            ST_ISSUE: begin
                if (mul_req.load) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (op_reg == OP_SCALE_D) begin
                    state_next = ST_SUM;
                end else begin
                    op_next    = op_reg + 3'd1;
                    state_next = ST_ISSUE;
                end
            end
            ST_SUM: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_INTEG;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            smooth_p_reg <= fpc_pkg::WEIGHT_ONE;
            smooth_d_reg <= fpc_pkg::WEIGHT_ONE;
            limit_reg    <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fpc_pkg::REG_GAIN_P:   gain_p_reg   <= cfg_data;
                fpc_pkg::REG_GAIN_I:   gain_i_reg   <= cfg_data;
                fpc_pkg::REG_GAIN_D:   gain_d_reg   <= cfg_data;
                fpc_pkg::REG_SMOOTH_P: smooth_p_reg <= cfg_data[SW-1:0];
                fpc_pkg::REG_SMOOTH_D: smooth_d_reg <= cfg_data[SW-1:0];
                fpc_pkg::REG_LIMIT:    limit_reg    <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Controller state changes only on a step that is not skipped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ferr_reg     <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            fslope_reg   <= '0;
        end else begin
            if (state_reg == ST_ACC) begin
                case (op_reg)
                    OP_INTEG:   integ_reg  <= integ_clamped[DW-1:0];
                    OP_BLEND_P: ferr_reg   <= acc_sat;
                    OP_BLEND_D: fslope_reg <= acc_sat;
                    default: ;
                endcase
            end
            if (state_reg == ST_SUM) begin
                last_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_CHECK) begin
            err_reg  <= err_sat;
            skip_reg <= skip;
            if (skip) begin
                p_reg     <= '0;
                i_reg     <= '0;
                d_reg     <= '0;
                drive_reg <= '0;
            end
        end
        if (state_reg == ST_ACC) begin
            case (op_reg)
                OP_SCALE_P: p_reg <= acc_sat;
                OP_SCALE_I: i_reg <= acc_sat;
                OP_SCALE_D: d_reg <= acc_sat;
                default: ;
            endcase
        end
        if (state_reg == ST_SUM) begin
            drive_reg <= fpc_pkg::sat_acc(sum3);
        end
        if (load_out) begin
            out_reg.drive      <= drive_reg;
            out_reg.prop_term  <= p_reg;
            out_reg.integ_term <= i_reg;
            out_reg.deriv_term <= d_reg;
            out_reg.skipped    <= skip_reg;
        end
    end

endmodule

// File: hdl/fpc_mul.sv
module fpc_mul (
    input  logic                                   aclk,
    input  fpc_pkg::mul_req_t                      req,
    output logic signed [fpc_pkg::PROD_W-1:0]      prod
);

    logic signed [fpc_pkg::OPND_W-1:0] a_reg;
    logic signed [fpc_pkg::OPND_W-1:0] b_reg;
    logic signed [fpc_pkg::PROD_W-1:0] prod_reg;

    // Operands are registered on load, and the product is registered from them in the following cycle.
    always_ff @(posedge aclk) begin
        if (req.load) begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        prod_reg <= a_reg * b_reg;
    end

    assign prod = prod_reg;

endmodule

// File: hdl/fpc_div.sv
module fpc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  fpc_pkg::div_req_t req,
    output fpc_pkg::div_rsp_t rsp
);

    localparam int DW    = fpc_pkg::DATA_W;
    localparam int OW    = fpc_pkg::OPND_W;
    localparam int FW    = fpc_pkg::FRAC_W;
    localparam int NW    = fpc_pkg::NUM_W;
    localparam int CW    = fpc_pkg::CNT_W;

    localparam logic [NW-1:0] POS_MAX = {{(NW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic [NW-1:0] NEG_MAG = POS_MAX + 1'b1;

    logic                 abs_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [OW-1:0] diff_reg;
    logic [DW-1:0]        den_reg;
    logic                 neg_reg;
    logic [NW-1:0]        num_reg;
    logic [DW-1:0]        rem_reg;

    logic [OW-1:0] mag;
    logic [DW:0]   rem_shift;
    logic [DW:0]   trial;
    logic          qbit;
    logic [NW-1:0] neg_quot;

    assign mag       = diff_reg[OW-1] ? -diff_reg : diff_reg;
    assign rem_shift = {rem_reg, num_reg[NW-1]};
    assign trial     = rem_shift - {1'b0, den_reg};
    assign qbit      = !trial[DW];
    assign neg_quot  = -num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            abs_reg  <= 1'b1;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (abs_reg) begin
            abs_reg  <= 1'b0;
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division on magnitudes, one quotient bit per cycle. The
    // numerator bits shift out at the top while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            diff_reg <= req.diff;
            den_reg  <= req.divisor;
        end else if (abs_reg) begin
            neg_reg <= diff_reg[OW-1];
            num_reg <= {mag, {FW{1'b0}}};
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= qbit ? trial[DW-1:0] : rem_shift[DW-1:0];
            num_reg <= {num_reg[NW-2:0], qbit};
        end
    end

    always_comb begin
        rsp.done = done_reg;
        if (neg_reg) begin
            rsp.quot = (num_reg > NEG_MAG) ? {1'b1, {(DW - 1){1'b0}}} : neg_quot[DW-1:0];
        end else begin
            rsp.quot = (num_reg > POS_MAX) ? {1'b0, {(DW - 1){1'b1}}} : num_reg[DW-1:0];
        end
    end

endmodule

// File: hdl/fpc_checker.sv
`include "filtered_pid_controller_core_macros.svh"

module fpc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input fpc_pkg::pid_out_t m_data
);

    logic signed [fpc_pkg::ACC_W-1:0]  chk_sum;
    logic signed [fpc_pkg::DATA_W-1:0] chk_drive;
    logic                              chk_zero;

    assign chk_sum   = fpc_pkg::ACC_W'(m_data.prop_term) + fpc_pkg::ACC_W'(m_data.integ_term)
                     + fpc_pkg::ACC_W'(m_data.deriv_term);
    assign chk_drive = fpc_pkg::sat_acc(chk_sum);
    assign chk_zero  = (m_data.drive == 0) && (m_data.prop_term == 0)
                     && (m_data.integ_term == 0) && (m_data.deriv_term == 0);

    // A result beat waiting on the consumer stays put.
    `FPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // A skipped step reports all terms and the drive as zero.
    `FPC_ASSERT_NOW(a_skip_zero, m_valid && m_data.skipped, chk_zero)

    // The drive is the saturated sum of the three reported terms.
    `FPC_ASSERT_NOW(a_drive_sum, m_valid && !m_data.skipped, m_data.drive == chk_drive)

    // Steps are processed one at a time, so input is closed right after a beat.
    `FPC_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind filtered_pid_controller_core fpc_checker u_fpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
